>>> rtl/core/lcdbw_pkg.sv
package lcdbw_pkg;

    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CMD    = 3'd1,
        OP_CHAR   = 3'd2,
        OP_NUMBER = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_SHIFT  = 3'd5,
        OP_HOME   = 3'd6,
        OP_GOTO   = 3'd7
    } lcdbw_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } lcdbw_state_t;

    localparam logic [7:0] FUNC_SET_8BIT  = 8'b0011_1000;
    localparam logic [7:0] FUNC_SET_4BIT  = 8'b0010_1000;
    localparam logic [7:0] DISPLAY_ON     = 8'b0000_1111;
    localparam logic [7:0] CLEAR_DISPLAY  = 8'b0000_0001;
    localparam logic [7:0] ENTRY_MODE     = 8'b0000_0110;
    localparam logic [7:0] SHIFT_LEFT     = 8'b0001_1000;
    localparam logic [7:0] SHIFT_RIGHT    = 8'b0001_1100;
    localparam logic [7:0] RETURN_HOME    = 8'b0000_0010;
    localparam logic [7:0] LINE0_BASE     = 8'h80;
    localparam logic [7:0] LINE1_BASE     = 8'hC0;
    localparam logic [7:0] ASCII_ZERO     = 8'h30;
    localparam logic [7:0] DEC_RADIX      = 8'd10;
    localparam logic [7:0] DEC_HUNDRED    = 8'd100;
    localparam logic [7:0] WAKE_NIBBLE    = 8'h02;

    localparam logic [15:0] WAIT_POWER_UP = 16'd40000;
    localparam logic [10:0] WAIT_SHORT    = 11'd45;
    localparam logic [10:0] WAIT_CURSOR   = 11'd50;
    localparam logic [10:0] WAIT_LONG     = 11'd2000;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] value;
        logic       line_select;
        logic [5:0] cursor_column;
        logic       shift_direction;
    } lcdbw_op_item_t;

    typedef struct packed {
        logic        register_select;
        logic [7:0]  bus_value;
        logic [15:0] wait_before_us;
        logic [10:0] wait_after_us;
        logic        last_strobe;
    } lcdbw_strobe_t;

    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } lcdbw_digit_ctrl_t;

    typedef struct packed {
        logic       done;
        logic [1:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
    } lcdbw_digit_stat_t;

endpackage

>>> rtl/core/lcdbw_digit_unit.sv
module lcdbw_digit_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcdbw_pkg::lcdbw_digit_ctrl_t ctrl,
    output lcdbw_pkg::lcdbw_digit_stat_t stat
);

    logic       busy_reg, busy_next;
    logic       phase_reg, phase_next;
    logic       done_reg, done_next;
    logic [7:0] residual_reg, residual_next;
    logic [1:0] hund_reg, hund_next;
    logic [3:0] tens_reg, tens_next;

    logic [7:0] divisor;
    logic       ge;

    // shared compare/subtract: hundreds pass, then tens pass
    assign divisor = phase_reg ? lcdbw_pkg::DEC_RADIX : lcdbw_pkg::DEC_HUNDRED;
    assign ge      = residual_reg >= divisor;

    always_comb
    begin
        busy_next     = busy_reg;
        phase_next    = phase_reg;
        done_next     = 1'b0;
        residual_next = residual_reg;
        hund_next     = hund_reg;
        tens_next     = tens_reg;
        if (ctrl.start)
        begin
            busy_next     = 1'b1;
            phase_next    = 1'b0;
            residual_next = ctrl.value;
            hund_next     = 2'd0;
            tens_next     = 4'd0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                residual_next = residual_reg - divisor;
                if (phase_reg)
                    tens_next = tens_reg + 4'd1;
                else
                    hund_next = hund_reg + 2'd1;
            end
            else if (!phase_reg)
                phase_next = 1'b1;
            else
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        residual_reg <= residual_next;
        hund_reg     <= hund_next;
        tens_reg     <= tens_next;
    end

    assign stat.done     = done_reg;
    assign stat.hundreds = hund_reg;
    assign stat.tens     = tens_reg;
    assign stat.ones     = residual_reg[3:0];

    a_done_rem: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (residual_reg < lcdbw_pkg::DEC_RADIX))
        else $error("digit unit finished with remainder not below ten");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("digit unit done while still busy");

    a_tens_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg) |-> (residual_reg < lcdbw_pkg::DEC_HUNDRED))
        else $error("tens pass entered with hundreds left");

endmodule

>>> rtl/core/lcdbw_sequencer.sv
module lcdbw_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         bus_mode,
    input  logic                         op_valid,
    output logic                         op_ready,
    input  lcdbw_pkg::lcdbw_op_item_t    op_data,
    output logic                         strobe_valid,
    input  logic                         strobe_ready,
    output lcdbw_pkg::lcdbw_strobe_t     strobe_data,
    output lcdbw_pkg::lcdbw_digit_ctrl_t dig_ctrl,
    input  lcdbw_pkg::lcdbw_digit_stat_t dig_stat
);

    typedef struct packed {
        logic        rs;
        logic [7:0]  data;
        logic [10:0] wait_after;
        logic        last;
    } byte_desc_t;

    lcdbw_pkg::lcdbw_state_t state_reg, state_next;

    logic [2:0] op_reg;
    logic [7:0] val_reg;
    logic       line_reg;
    logic [5:0] col_reg;
    logic       dir_reg;
    logic       mode_reg;
    logic [1:0] step_reg, step_next;
    logic       nib_reg, nib_next;
    logic       pre_reg, pre_next;
    logic       out_valid_reg, out_valid_next;
    lcdbw_pkg::lcdbw_strobe_t out_data_reg, out_data_next;

    logic       accept;
    logic       emit;
    byte_desc_t cur;

    assign accept = op_valid && op_ready;
    assign emit   = (state_reg == lcdbw_pkg::S_EMIT) && (!out_valid_reg || strobe_ready);

    always_comb
    begin
        cur = '{rs: 1'b0, data: 8'h00, wait_after: 11'd0, last: 1'b1};
        case (op_reg)
            lcdbw_pkg::OP_INIT:
            begin
                cur.last = (step_reg == 2'd3);
                case (step_reg)
                    2'd0:
                    begin
                        cur.data       = mode_reg ? lcdbw_pkg::FUNC_SET_4BIT
                                                  : lcdbw_pkg::FUNC_SET_8BIT;
                        cur.wait_after = lcdbw_pkg::WAIT_SHORT;
                    end
                    2'd1:
                    begin
                        cur.data       = lcdbw_pkg::DISPLAY_ON;
                        cur.wait_after = lcdbw_pkg::WAIT_SHORT;
                    end
                    2'd2:
                    begin
                        cur.data       = lcdbw_pkg::CLEAR_DISPLAY;
                        cur.wait_after = lcdbw_pkg::WAIT_LONG;
                    end
                    default:
                    begin
                        cur.data       = lcdbw_pkg::ENTRY_MODE;
                        cur.wait_after = lcdbw_pkg::WAIT_LONG;
                    end
                endcase
            end
            lcdbw_pkg::OP_CMD:
                cur.data = val_reg;
            lcdbw_pkg::OP_CHAR:
            begin
                cur.rs   = 1'b1;
                cur.data = val_reg;
            end
            lcdbw_pkg::OP_NUMBER:
            begin
                cur.rs   = 1'b1;
                cur.last = (step_reg == 2'd2);
                case (step_reg)
                    2'd0:    cur.data = lcdbw_pkg::ASCII_ZERO + {6'd0, dig_stat.hundreds};
                    2'd1:    cur.data = lcdbw_pkg::ASCII_ZERO + {4'd0, dig_stat.tens};
                    default: cur.data = lcdbw_pkg::ASCII_ZERO + {4'd0, dig_stat.ones};
                endcase
            end
            lcdbw_pkg::OP_CLEAR:
            begin
                cur.data       = lcdbw_pkg::CLEAR_DISPLAY;
                cur.wait_after = lcdbw_pkg::WAIT_LONG;
            end
            lcdbw_pkg::OP_SHIFT:
            begin
                cur.data       = dir_reg ? lcdbw_pkg::SHIFT_RIGHT : lcdbw_pkg::SHIFT_LEFT;
                cur.wait_after = lcdbw_pkg::WAIT_CURSOR;
            end
            lcdbw_pkg::OP_HOME:
            begin
                cur.data       = lcdbw_pkg::RETURN_HOME;
                cur.wait_after = lcdbw_pkg::WAIT_CURSOR;
            end
            default:
            begin
                cur.data       = (line_reg ? lcdbw_pkg::LINE1_BASE : lcdbw_pkg::LINE0_BASE)
                                 + {2'd0, col_reg};
                cur.wait_after = lcdbw_pkg::WAIT_CURSOR;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcdbw_pkg::S_IDLE:
                if (accept)
                    state_next = (op_data.operation == lcdbw_pkg::OP_NUMBER)
                                 ? lcdbw_pkg::S_DIV : lcdbw_pkg::S_EMIT;
            lcdbw_pkg::S_DIV:
                if (dig_stat.done)
                    state_next = lcdbw_pkg::S_EMIT;
            lcdbw_pkg::S_EMIT:
                if (emit && !pre_reg && cur.last && (!mode_reg || nib_reg))
                    state_next = lcdbw_pkg::S_IDLE;
            default:
                state_next = lcdbw_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        op_ready       = (state_reg == lcdbw_pkg::S_IDLE);
        dig_ctrl.start = accept && (op_data.operation == lcdbw_pkg::OP_NUMBER);
        dig_ctrl.value = op_data.value;
        step_next      = step_reg;
        nib_next       = nib_reg;
        pre_next       = pre_reg;
        out_valid_next = out_valid_reg && !strobe_ready;
        out_data_next  = out_data_reg;

        if (accept)
        begin
            step_next = 2'd0;
            nib_next  = 1'b0;
            pre_next  = (op_data.operation == lcdbw_pkg::OP_INIT) && bus_mode;
        end
        else if ((state_reg == lcdbw_pkg::S_DIV) && dig_stat.done)
        begin
            if (dig_stat.hundreds != 2'd0)
                step_next = 2'd0;
            else if (dig_stat.tens != 4'd0)
                step_next = 2'd1;
            else
                step_next = 2'd2;
        end

        if (emit)
        begin
            out_valid_next                = 1'b1;
            out_data_next.register_select = cur.rs;
            out_data_next.wait_before_us  = 16'd0;
            out_data_next.wait_after_us   = 11'd0;
            out_data_next.last_strobe     = 1'b0;
            if (pre_reg)
            begin
                out_data_next.register_select = 1'b0;
                out_data_next.bus_value       = lcdbw_pkg::WAKE_NIBBLE;
                out_data_next.wait_before_us  = lcdbw_pkg::WAIT_POWER_UP;
                pre_next                      = 1'b0;
            end
            else if (!mode_reg)
            begin
                out_data_next.bus_value     = cur.data;
                out_data_next.wait_after_us = cur.wait_after;
                out_data_next.last_strobe   = cur.last;
                if ((op_reg == lcdbw_pkg::OP_INIT) && (step_reg == 2'd0))
                    out_data_next.wait_before_us = lcdbw_pkg::WAIT_POWER_UP;
                step_next = step_reg + 2'd1;
            end
            else if (!nib_reg)
            begin
                out_data_next.bus_value = {4'd0, cur.data[7:4]};
                nib_next                = 1'b1;
            end
            else
            begin
                out_data_next.bus_value     = {4'd0, cur.data[3:0]};
                out_data_next.wait_after_us = cur.wait_after;
                out_data_next.last_strobe   = cur.last;
                nib_next                    = 1'b0;
                step_next                   = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdbw_pkg::S_IDLE;
            step_reg      <= 2'd0;
            nib_reg       <= 1'b0;
            pre_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            nib_reg       <= nib_next;
            pre_reg       <= pre_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept)
        begin
            op_reg   <= op_data.operation;
            val_reg  <= op_data.value;
            line_reg <= op_data.line_select;
            col_reg  <= op_data.cursor_column;
            dir_reg  <= op_data.shift_direction;
            mode_reg <= bus_mode;
        end
    end

    assign strobe_valid = out_valid_reg;
    assign strobe_data  = out_data_reg;

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !pre_reg && cur.last && (!mode_reg || nib_reg))
        |=> (state_reg == lcdbw_pkg::S_IDLE))
        else $error("sequencer did not return to idle after final strobe");

    a_byte_mode_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lcdbw_pkg::S_IDLE && !mode_reg) |-> (!nib_reg && !pre_reg))
        else $error("nibble phase active on 8-bit bus");

    a_wait_before: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.wait_before_us != 16'd0))
        |-> (op_reg == lcdbw_pkg::OP_INIT))
        else $error("power-up wait on non-init transaction");

endmodule

>>> rtl/core/char_lcd_bus_write_sequencer_top.sv
// Character LCD bus write sequencer. Each accepted operation is expanded into
// enable-strobe transactions (register select, bus value, waits, last mark), one
// per cycle while the output side keeps taking them; the port takes no new
// operation until the final strobe of the current one has been loaded into the
// output register. A non-number operation yields 1 to 9 strobes. A number
// operation first runs a shared compare/subtract unit that peels off hundreds
// and then tens before its 1 to 6 strobes. cfg_ready is always high; bus_mode
// is sampled at the start of each operation.
module char_lcd_bus_write_sequencer_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_data,
    input  logic                     op_valid,
    output logic                     op_ready,
    input  lcdbw_pkg::lcdbw_op_item_t op_data,
    output logic                     strobe_valid,
    input  logic                     strobe_ready,
    output lcdbw_pkg::lcdbw_strobe_t strobe_data
);

    logic bus_mode_reg;

    lcdbw_pkg::lcdbw_digit_ctrl_t dig_ctrl;
    lcdbw_pkg::lcdbw_digit_stat_t dig_stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bus_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            bus_mode_reg <= cfg_data;
    end

    lcdbw_digit_unit u_digit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dig_ctrl),
        .stat  (dig_stat)
    );

    lcdbw_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .bus_mode     (bus_mode_reg),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op_data      (op_data),
        .strobe_valid (strobe_valid),
        .strobe_ready (strobe_ready),
        .strobe_data  (strobe_data),
        .dig_ctrl     (dig_ctrl),
        .dig_stat     (dig_stat)
    );

endmodule

>>> tb/tb_char_lcd_bus_write_sequencer_top.sv
`timescale 1ns / 100ps

module tb_char_lcd_bus_write_sequencer_top;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned HOLD_CYCLES  = 600;
    localparam int unsigned SETTLE       = 20;
    localparam int unsigned PRINT_CAP    = 40;

    localparam logic [7:0]  CMD_FUNC_8BIT  = 8'h38;
    localparam logic [7:0]  CMD_FUNC_4BIT  = 8'h28;
    localparam logic [7:0]  CMD_WAKE       = 8'h02;
    localparam logic [7:0]  CMD_DISP_ON    = 8'h0F;
    localparam logic [7:0]  CMD_CLEAR      = 8'h01;
    localparam logic [7:0]  CMD_ENTRY      = 8'h06;
    localparam logic [7:0]  CMD_SHIFT_L    = 8'h18;
    localparam logic [7:0]  CMD_SHIFT_R    = 8'h1C;
    localparam logic [7:0]  CMD_HOME       = 8'h02;
    localparam logic [7:0]  DDRAM_LINE0    = 8'h80;
    localparam logic [7:0]  DDRAM_LINE1    = 8'hC0;
    localparam logic [7:0]  DIGIT_ZERO     = 8'h30;
    localparam logic [15:0] POWER_UP_US    = 16'd40000;
    localparam logic [10:0] SHORT_US       = 11'd45;
    localparam logic [10:0] CURSOR_US      = 11'd50;
    localparam logic [10:0] LONG_US        = 11'd2000;
    localparam logic        RS_CMD         = 1'b0;
    localparam logic        RS_DATA        = 1'b1;
    localparam logic        MODE_8BIT      = 1'b0;
    localparam logic        MODE_4BIT      = 1'b1;

    class lcd_strobe_scoreboard;
        logic                    nibble_mode;
        lcdbw_pkg::lcdbw_strobe_t expected_strobes[$];
        int unsigned             errors;
        int unsigned             strobe_count;

        function new();
            nibble_mode  = MODE_8BIT;
            errors       = 0;
            strobe_count = 0;
        endfunction

        task report(input string msg);
            if (errors < PRINT_CAP)
                $display("%0t mismatch: %s", $time, msg);
            errors++;
        endtask

        function void push_strobe(input logic rs, input logic [7:0] bus,
                                  input logic [15:0] before_us, input logic [10:0] after_us);
            lcdbw_pkg::lcdbw_strobe_t s;
            s.register_select = rs;
            s.bus_value       = bus;
            s.wait_before_us  = before_us;
            s.wait_after_us   = after_us;
            s.last_strobe     = 1'b0;
            expected_strobes.push_back(s);
        endfunction

        function void push_byte(input logic rs, input logic [7:0] b,
                                input logic [15:0] before_us, input logic [10:0] after_us);
            if (nibble_mode == MODE_4BIT)
            begin
                push_strobe(rs, {4'h0, b[7:4]}, before_us, 11'd0);
                push_strobe(rs, {4'h0, b[3:0]}, 16'd0, after_us);
            end
            else
                push_strobe(rs, b, before_us, after_us);
        endfunction

        function void expand_operation(input lcdbw_pkg::lcdbw_op_item_t item);
            int unsigned hundreds;
            int unsigned tens;
            int unsigned ones;
            case (lcdbw_pkg::lcdbw_op_t'(item.operation))
                lcdbw_pkg::OP_INIT:
                begin
                    if (nibble_mode == MODE_4BIT)
                    begin
                        push_strobe(RS_CMD, CMD_WAKE, POWER_UP_US, 11'd0);
                        push_byte(RS_CMD, CMD_FUNC_4BIT, 16'd0, SHORT_US);
                    end
                    else
                        push_byte(RS_CMD, CMD_FUNC_8BIT, POWER_UP_US, SHORT_US);
                    push_byte(RS_CMD, CMD_DISP_ON, 16'd0, SHORT_US);
                    push_byte(RS_CMD, CMD_CLEAR, 16'd0, LONG_US);
                    push_byte(RS_CMD, CMD_ENTRY, 16'd0, LONG_US);
                end
                lcdbw_pkg::OP_CMD:   push_byte(RS_CMD, item.value, 16'd0, 11'd0);
                lcdbw_pkg::OP_CHAR:  push_byte(RS_DATA, item.value, 16'd0, 11'd0);
                lcdbw_pkg::OP_NUMBER:
                begin
                    hundreds = item.value / 100;
                    tens     = (item.value / 10) % 10;
                    ones     = item.value % 10;
                    if (hundreds != 0)
                        push_byte(RS_DATA, DIGIT_ZERO + 8'(hundreds), 16'd0, 11'd0);
                    if (hundreds != 0 || tens != 0)
                        push_byte(RS_DATA, DIGIT_ZERO + 8'(tens), 16'd0, 11'd0);
                    push_byte(RS_DATA, DIGIT_ZERO + 8'(ones), 16'd0, 11'd0);
                end
                lcdbw_pkg::OP_CLEAR: push_byte(RS_CMD, CMD_CLEAR, 16'd0, LONG_US);
                lcdbw_pkg::OP_SHIFT: push_byte(RS_CMD,
                                               item.shift_direction ? CMD_SHIFT_R : CMD_SHIFT_L,
                                               16'd0, CURSOR_US);
                lcdbw_pkg::OP_HOME:  push_byte(RS_CMD, CMD_HOME, 16'd0, CURSOR_US);
                default:  push_byte(RS_CMD, (item.line_select ? DDRAM_LINE1 : DDRAM_LINE0)
                                    + {2'b00, item.cursor_column}, 16'd0, CURSOR_US);
            endcase
            expected_strobes[expected_strobes.size() - 1].last_strobe = 1'b1;
        endfunction

        function void note_operation(input lcdbw_pkg::lcdbw_op_item_t item);
            expand_operation(item);
        endfunction

        task check_strobe(input lcdbw_pkg::lcdbw_strobe_t got);
            lcdbw_pkg::lcdbw_strobe_t want;
            strobe_count++;
            if (expected_strobes.size() == 0)
            begin
                report($sformatf("strobe %0d unexpected: rs=%0b bus=%02h",
                                 strobe_count, got.register_select, got.bus_value));
                return;
            end
            want = expected_strobes.pop_front();
            if (got.register_select !== want.register_select)
                report($sformatf("strobe %0d register_select %0b, want %0b",
                                 strobe_count, got.register_select, want.register_select));
            if (got.bus_value !== want.bus_value)
                report($sformatf("strobe %0d bus_value %02h, want %02h",
                                 strobe_count, got.bus_value, want.bus_value));
            if (got.wait_before_us !== want.wait_before_us)
                report($sformatf("strobe %0d wait_before_us %0d, want %0d",
                                 strobe_count, got.wait_before_us, want.wait_before_us));
            if (got.wait_after_us !== want.wait_after_us)
                report($sformatf("strobe %0d wait_after_us %0d, want %0d",
                                 strobe_count, got.wait_after_us, want.wait_after_us));
            if (got.last_strobe !== want.last_strobe)
                report($sformatf("strobe %0d last_strobe %0b, want %0b",
                                 strobe_count, got.last_strobe, want.last_strobe));
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_data;
    logic                      op_valid;
    logic                      op_ready;
    lcdbw_pkg::lcdbw_op_item_t op_data;
    logic                      strobe_valid;
    logic                      strobe_ready;
    lcdbw_pkg::lcdbw_strobe_t  strobe_data;

    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    bit             hold_armed;
    logic           hold_off;
    int unsigned    cycle_count;

    lcd_strobe_scoreboard display_ops;

    char_lcd_bus_write_sequencer_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .op_valid     (op_valid),
        .op_ready     (op_ready),
        .op_data      (op_data),
        .strobe_valid (strobe_valid),
        .strobe_ready (strobe_ready),
        .strobe_data  (strobe_data)
    );

    always #5 clk = ~clk;

    // receiver: random stalls plus the long hold-off
    initial
    begin
        strobe_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            strobe_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        hold_off <= 1'b0;
        wait (hold_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && strobe_valid === 1'b1 && strobe_ready === 1'b1)
            display_ops.check_strobe(strobe_data);
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic lcdbw_pkg::lcdbw_op_item_t make_op(input lcdbw_pkg::lcdbw_op_t op,
                                                          input logic [7:0] val,
                                                          input logic line,
                                                          input logic [5:0] col,
                                                          input logic dir);
        lcdbw_pkg::lcdbw_op_item_t item;
        item.operation       = op;
        item.value           = val;
        item.line_select     = line;
        item.cursor_column   = col;
        item.shift_direction = dir;
        return item;
    endfunction

    function automatic lcdbw_pkg::lcdbw_op_item_t random_op();
        lcdbw_pkg::lcdbw_op_item_t item;
        item.operation       = 3'($urandom_range(0, 7));
        item.value           = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 20))
                                                           : 8'($urandom_range(0, 255));
        item.line_select     = 1'($urandom_range(0, 1));
        item.cursor_column   = 6'($urandom_range(0, 63));
        item.shift_direction = 1'($urandom_range(0, 1));
        return item;
    endfunction

    task automatic send_op(input lcdbw_pkg::lcdbw_op_item_t item);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            op_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        op_valid <= 1'b1;
        op_data  <= item;
        do @(posedge clk); while (op_ready !== 1'b1);
        display_ops.note_operation(item);
    endtask

    task automatic write_bus_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        display_ops.nibble_mode = mode;
    endtask

    task automatic drain();
        op_valid <= 1'b0;
        while (display_ops.expected_strobes.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input logic mode, input int unsigned send_pct,
                             input int unsigned stall_pct, input int unsigned count,
                             input bit pressure);
        write_bus_mode(mode);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        hold_armed     = pressure;
        repeat (count) send_op(random_op());
        drain();
    endtask

    initial
    begin
        display_ops    = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b0;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        op_valid  <= 1'b0;
        op_data   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, register at its reset value
        send_op(make_op(lcdbw_pkg::OP_INIT,   8'h00, 1'b0, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_CMD,    8'h00, 1'b1, 6'd63, 1'b1));
        send_op(make_op(lcdbw_pkg::OP_CMD,    8'hFF, 1'b0, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_CHAR,   8'h00, 1'b0, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_CHAR,   8'hFF, 1'b1, 6'd63, 1'b1));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd0,   1'b0, 6'd0, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd9,   1'b0, 6'd0, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd10,  1'b0, 6'd0, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd99,  1'b0, 6'd0, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd100, 1'b0, 6'd0, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd205, 1'b0, 6'd0, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd255, 1'b1, 6'd63, 1'b1));
        send_op(make_op(lcdbw_pkg::OP_CLEAR,  8'hFF, 1'b1, 6'd63, 1'b1));
        send_op(make_op(lcdbw_pkg::OP_SHIFT,  8'h00, 1'b0, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_SHIFT,  8'h00, 1'b0, 6'd0,  1'b1));
        send_op(make_op(lcdbw_pkg::OP_HOME,   8'hFF, 1'b1, 6'd63, 1'b1));
        send_op(make_op(lcdbw_pkg::OP_GOTO,   8'h00, 1'b0, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_GOTO,   8'h00, 1'b0, 6'd63, 1'b0));
        send_op(make_op(lcdbw_pkg::OP_GOTO,   8'h00, 1'b1, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_GOTO,   8'hFF, 1'b1, 6'd63, 1'b1));
        drain();

        // nibble bus init straight after a mode change
        write_bus_mode(MODE_4BIT);
        send_op(make_op(lcdbw_pkg::OP_INIT,   8'h00, 1'b0, 6'd0,  1'b0));
        send_op(make_op(lcdbw_pkg::OP_NUMBER, 8'd255, 1'b0, 6'd0, 1'b0));
        drain();

        run_phase(MODE_8BIT, 0,  0,  50, 1'b0);
        run_phase(MODE_4BIT, 74, 0,  50, 1'b0);
        run_phase(MODE_8BIT, 0,  74, 50, 1'b0);
        run_phase(MODE_4BIT, 6,  6,  50, 1'b0);
        run_phase(MODE_4BIT, 0,  0,  30, 1'b1);
        run_phase(MODE_8BIT, 6,  6,  20, 1'b0);

        if (display_ops.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> char_lcd_bus_write_sequencer_top.f
rtl/core/lcdbw_pkg.sv
rtl/core/lcdbw_digit_unit.sv
rtl/core/lcdbw_sequencer.sv
rtl/core/char_lcd_bus_write_sequencer_top.sv
tb/tb_char_lcd_bus_write_sequencer_top.sv
